// ===== sv/pics_pkg.sv =====
// shared types, codes and microcode program of the pi controller
package pics_pkg;

	localparam int unsigned StepW = 4;

	// request codes
	localparam logic [1:0] REQ_UPDATE = 2'd0;
	localparam logic [1:0] REQ_PRESET = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_SETPOINT = 3'd0;
	localparam logic [2:0] CFG_KP_GAIN  = 3'd1;
	localparam logic [2:0] CFG_KI       = 3'd2;
	localparam logic [2:0] CFG_OUT_MAX  = 3'd3;
	localparam logic [2:0] CFG_OUT_MIN  = 3'd4;
	localparam logic [2:0] CFG_SLEW     = 3'd5;

	typedef logic [StepW-1:0] step_t;

	// program addresses
	localparam step_t ST_ERR   = 4'd0;
	localparam step_t ST_MULP  = 4'd1;
	localparam step_t ST_MULKI = 4'd2;
	localparam step_t ST_SATLO = 4'd3;
	localparam step_t ST_HI    = 4'd4;
	localparam step_t ST_INC   = 4'd5;
	localparam step_t ST_ACC   = 4'd6;
	localparam step_t ST_USUM  = 4'd7;
	localparam step_t ST_SCALE = 4'd8;
	localparam step_t ST_LIM   = 4'd9;
	localparam step_t ST_PRE1  = 4'd10;
	localparam step_t ST_PRE2  = 4'd11;
	localparam step_t ST_CLR   = 4'd12;
	localparam step_t ST_HOLD  = 4'd13;

	typedef enum logic [3:0] {
		OP_ERR, OP_MULP, OP_MULKI, OP_SATLO, OP_HI, OP_INC, OP_ACC,
		OP_USUM, OP_SCALE, OP_LIM, OP_PRE1, OP_PRE2, OP_CLR, OP_HOLD
	} op_t;

	typedef enum logic [2:0] {
		C_NONE, C_PRESET, C_CLEAR, C_HOLD, C_SAT
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  last;
	} ucode_t;

	typedef struct packed {
		logic signed [15:0] setpoint;
		logic        [15:0] kp_gain;
		logic        [23:0] ki_per_ms;
		logic signed [8:0]  out_max;
		logic signed [8:0]  out_min;
		logic        [8:0]  slew_limit;
	} cfg_t;

	typedef struct packed {
		logic preset;
		logic clear;
		logic hold;
		logic sat;
	} status_t;

	typedef struct packed {
		op_t  op;
		logic en;
		logic done;
	} ctrl_t;

	function automatic ucode_t ucode(input step_t step);
		ucode_t w;
		case (step)
			ST_ERR:   w = '{OP_ERR,   C_PRESET, ST_PRE1, 1'b0};
			ST_MULP:  w = '{OP_MULP,  C_CLEAR,  ST_CLR,  1'b0};
			ST_MULKI: w = '{OP_MULKI, C_HOLD,   ST_HOLD, 1'b0};
			ST_SATLO: w = '{OP_SATLO, C_SAT,    ST_USUM, 1'b0};
			ST_HI:    w = '{OP_HI,    C_NONE,   ST_ERR,  1'b0};
			ST_INC:   w = '{OP_INC,   C_NONE,   ST_ERR,  1'b0};
			ST_ACC:   w = '{OP_ACC,   C_NONE,   ST_ERR,  1'b0};
			ST_USUM:  w = '{OP_USUM,  C_NONE,   ST_ERR,  1'b0};
			ST_SCALE: w = '{OP_SCALE, C_NONE,   ST_ERR,  1'b0};
			ST_LIM:   w = '{OP_LIM,   C_NONE,   ST_ERR,  1'b1};
			ST_PRE1:  w = '{OP_PRE1,  C_NONE,   ST_ERR,  1'b0};
			ST_PRE2:  w = '{OP_PRE2,  C_NONE,   ST_ERR,  1'b1};
			ST_CLR:   w = '{OP_CLR,   C_NONE,   ST_ERR,  1'b1};
			ST_HOLD:  w = '{OP_HOLD,  C_NONE,   ST_ERR,  1'b1};
			default:  w = '{OP_HOLD,  C_NONE,   ST_ERR,  1'b1};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/pics_seq.sv =====
// microcode sequencer: step counter, program table and conditional jumps
module pics_seq import pics_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    out_free,
	input  status_t status,
	output ctrl_t   ctrl,
	output logic    busy
);

	logic   busy_q;
	step_t  step_q;
	ucode_t cw;
	logic   taken;
	logic   adv;

	assign cw = ucode(step_q);

	always_comb begin
		case (cw.cond)
			C_PRESET: taken = status.preset;
			C_CLEAR:  taken = status.clear;
			C_HOLD:   taken = status.hold;
			C_SAT:    taken = status.sat;
			default:  taken = 1'b0;
		endcase
	end

	// the closing step waits until the output register can take the beat
	assign adv = busy_q && (!cw.last || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_ERR;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= ST_ERR;
		end else if (adv) begin
			if (cw.last) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= taken ? cw.target : step_q + 1'b1;
			end
		end
	end

	assign ctrl.op   = cw.op;
	assign ctrl.en   = adv;
	assign ctrl.done = adv && cw.last;
	assign busy      = busy_q;

endmodule

// ===== sv/pics_dp.sv =====
// datapath: shared multiplier, integrator, scaling, limits and slew
module pics_dp import pics_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] measured_speed,
	input  logic [15:0]        elapsed_ms,
	input  logic signed [8:0]  preset_pwm,
	input  cfg_t               cfg,
	input  ctrl_t              ctrl,
	output status_t            status,
	output logic signed [8:0]  res_pwm,
	output logic               res_sat
);

	localparam logic signed [41:0] OneQ24 = 42'sd16777216;
	localparam logic signed [25:0] UMax   = 26'sd16777216;
	localparam logic signed [54:0] AccMax = 55'sd2147483647;
	localparam logic signed [54:0] AccMin = -55'sd2147483648;

	function automatic logic signed [9:0] clamp_lim(input logic signed [9:0] v,
		input logic signed [9:0] lo, input logic signed [9:0] hi);
		logic signed [9:0] r;
		if (v < lo) r = lo;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

	// captured beat
	logic [1:0]         req_q;
	logic signed [15:0] speed_q;
	logic [15:0]        dt_q;
	logic signed [8:0]  preset_q;

	logic signed [16:0] e_q;
	logic [40:0]        mul_q;
	logic [40:0]        kie_q;
	logic [36:0]        lo_q;
	logic [52:0]        inc_q;
	logic signed [40:0] p_q;
	logic signed [25:0] u_q;
	logic signed [9:0]  pwm0_q;
	logic signed [9:0]  p0_q;
	logic               sat_q;
	logic signed [31:0] acc_q;
	logic signed [8:0]  prev_q;

	logic [16:0]        e_abs;
	logic signed [9:0]  mx_raw, hi, lo;
	logic [23:0]        mul_a;
	logic [16:0]        mul_b;
	logic [40:0]        mul_y;
	logic [39:0]        p_mag;
	logic signed [40:0] p_next;
	logic signed [41:0] pre;
	logic               sat_now;
	logic [56:0]        inc_sum;
	logic signed [54:0] acc_sum;
	logic signed [31:0] acc_sat;
	logic signed [25:0] u_next;
	logic [24:0]        ua;
	logic [32:0]        sc;
	logic [8:0]         mag;
	logic signed [9:0]  pwm0_next;
	logic signed [9:0]  lim;
	logic signed [10:0] du, sl, slew_res;
	logic [8:0]         m;
	logic [24:0]        q;
	logic signed [31:0] acc_pre;

	assign e_abs = e_q[16] ? 17'(-e_q) : 17'(e_q);

	// pwm limits: negative upper limit uses its magnitude, non-negative lower is symmetric
	assign mx_raw = 10'(cfg.out_max);
	assign hi     = mx_raw[9] ? -mx_raw : mx_raw;
	assign lo     = cfg.out_min[8] ? 10'(cfg.out_min) : -hi;

	always_comb begin
		case (ctrl.op)
			OP_MULP: begin
				mul_a = {8'd0, cfg.kp_gain};
				mul_b = e_abs;
			end
			OP_MULKI: begin
				mul_a = cfg.ki_per_ms;
				mul_b = e_abs;
			end
			OP_SATLO: begin
				mul_a = {3'd0, mul_q[20:0]};
				mul_b = {1'b0, dt_q};
			end
			OP_HI: begin
				mul_a = {4'd0, kie_q[40:21]};
				mul_b = {1'b0, dt_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_y = 41'(mul_a) * 41'(mul_b);

	// proportional term in q.24
	assign p_mag  = {mul_q[31:0], 8'd0};
	assign p_next = e_q[16] ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});

	assign pre     = 42'(p_q) + 42'(acc_q);
	assign sat_now = (pre <= -OneQ24) || (pre >= OneQ24);

	// ki*|e|*dt from two partial products, then round off four bits
	assign inc_sum = {mul_q[35:0], 21'd0} + 57'(lo_q) + 57'd8;
	assign acc_sum = 55'(acc_q) +
		(e_q[16] ? -$signed({2'b00, inc_q}) : $signed({2'b00, inc_q}));

	always_comb begin
		if (acc_sum > AccMax) acc_sat = 32'sh7fffffff;
		else if (acc_sum < AccMin) acc_sat = 32'sh80000000;
		else acc_sat = acc_sum[31:0];
	end

	always_comb begin
		if (pre > 42'(UMax)) u_next = UMax;
		else if (pre < -42'(UMax)) u_next = -UMax;
		else u_next = pre[25:0];
	end

	// |u|*255 as shift and subtract, rounded half away from zero
	assign ua        = u_q[25] ? 25'(-u_q) : 25'(u_q);
	assign sc        = {ua, 8'd0} - 33'(ua) + 33'd8388608;
	assign mag       = sc[32:24];
	assign pwm0_next = u_q[25] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

	assign lim = clamp_lim(pwm0_q, lo, hi);
	assign du  = 11'(lim) - 11'(prev_q);
	assign sl  = $signed({2'b00, cfg.slew_limit});

	always_comb begin
		if (du > sl) slew_res = 11'(prev_q) + sl;
		else if (du < -sl) slew_res = 11'(prev_q) - sl;
		else slew_res = 11'(lim);
	end

	// preset integral: m*2^24/255 = m*0x10101 plus one from m >= 128 on
	assign m       = p0_q[9] ? 9'(-p0_q) : 9'(p0_q);
	assign q       = {m, 16'd0} + 25'({m, 8'd0}) + 25'(m) + 25'(m >= 9'd128);
	assign acc_pre = p0_q[9] ? -$signed({7'd0, q}) : $signed({7'd0, q});

	always_ff @(posedge clk) begin
		if (load) begin
			req_q    <= req_type;
			speed_q  <= measured_speed;
			dt_q     <= elapsed_ms;
			preset_q <= preset_pwm;
		end
		if (ctrl.en) begin
			case (ctrl.op)
				OP_ERR:   e_q <= 17'(cfg.setpoint) - 17'(speed_q);
				OP_MULP:  mul_q <= mul_y;
				OP_MULKI: begin
					mul_q <= mul_y;
					p_q   <= p_next;
				end
				OP_SATLO: begin
					sat_q <= sat_now;
					kie_q <= mul_q;
					mul_q <= mul_y;
				end
				OP_HI: begin
					lo_q  <= mul_q[36:0];
					mul_q <= mul_y;
				end
				OP_INC:   inc_q <= inc_sum[56:4];
				OP_USUM:  u_q <= u_next;
				OP_SCALE: pwm0_q <= pwm0_next;
				OP_PRE1:  p0_q <= clamp_lim(10'(preset_q), lo, hi);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			prev_q <= '0;
		end else if (ctrl.en) begin
			case (ctrl.op)
				OP_ACC: acc_q <= acc_sat;
				OP_LIM: prev_q <= slew_res[8:0];
				OP_PRE2: begin
					acc_q  <= acc_pre;
					prev_q <= p0_q[8:0];
				end
				OP_CLR: begin
					acc_q  <= '0;
					prev_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign status.preset = (req_q == REQ_PRESET);
	assign status.clear  = (req_q == REQ_CLEAR);
	assign status.hold   = !((req_q == REQ_UPDATE) && (dt_q != '0));
	assign status.sat    = sat_now;

	always_comb begin
		case (ctrl.op)
			OP_LIM:  res_pwm = slew_res[8:0];
			OP_PRE2: res_pwm = p0_q[8:0];
			OP_CLR:  res_pwm = '0;
			default: res_pwm = prev_q;
		endcase
	end

	assign res_sat = (ctrl.op == OP_LIM) && sat_q;

endmodule

// ===== sv/pi_controller_antiwindup_slew.sv =====
// top level: config registers, sequencer, datapath and output register
// PI speed controller with clamping anti-windup and output slew limit. One
// beat in gives one beat out. The block takes one request at a time; a request
// is taken the cycle after the previous one has left the sequencer, while its
// result may still wait in the output register. The microcode program runs
// the error, the P term and the two partial products of the integral step in
// turn through one shared 24x17 multiplier, then scales, limits and slews; an
// update whose PI sum is saturated skips the rest of the integral step, and
// zero elapsed time, an unused request code, preset and clear take short
// branches. Configuration writes take effect at once and belong between requests.
module pi_controller_antiwindup_slew import pics_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] measured_speed,
	input  logic [15:0]        elapsed_ms,
	input  logic signed [8:0]  preset_pwm,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [8:0]  pwm_out,
	output logic               saturated
);

	cfg_t              cfg_q;
	status_t           status;
	ctrl_t             ctrl;
	logic              busy;
	logic              load;
	logic              out_free;
	logic              out_valid_q;
	logic signed [8:0] pwm_q;
	logic              sat_out_q;
	logic signed [8:0] res_pwm;
	logic              res_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint   <= 16'sd0;
			cfg_q.kp_gain    <= 16'd256;
			cfg_q.ki_per_ms  <= 24'd0;
			cfg_q.out_max    <= 9'sd255;
			cfg_q.out_min    <= -9'sd255;
			cfg_q.slew_limit <= 9'd510;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SETPOINT: cfg_q.setpoint   <= cfg_data[15:0];
				CFG_KP_GAIN:  cfg_q.kp_gain    <= cfg_data[15:0];
				CFG_KI:       cfg_q.ki_per_ms  <= cfg_data;
				CFG_OUT_MAX:  cfg_q.out_max    <= cfg_data[8:0];
				CFG_OUT_MIN:  cfg_q.out_min    <= cfg_data[8:0];
				CFG_SLEW:     cfg_q.slew_limit <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign in_stall = busy;
	assign load     = in_valid && !busy;
	assign out_free = !out_valid_q || !out_stall;

	pics_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (load),
		.out_free (out_free),
		.status   (status),
		.ctrl     (ctrl),
		.busy     (busy)
	);

	pics_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (load),
		.req_type       (req_type),
		.measured_speed (measured_speed),
		.elapsed_ms     (elapsed_ms),
		.preset_pwm     (preset_pwm),
		.cfg            (cfg_q),
		.ctrl           (ctrl),
		.status         (status),
		.res_pwm        (res_pwm),
		.res_sat        (res_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.done) begin
			pwm_q     <= res_pwm;
			sat_out_q <= res_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign pwm_out   = pwm_q;
	assign saturated = sat_out_q;

	// a finishing step never overwrites a beat that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.done |-> out_free)
		else $error("result written over a pending output beat");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.done))
		else $error("output valid raised without a finished request");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("sequencer not busy after an accepted beat");

endmodule
